// ===== design/sorted_set_store_assert.svh =====
// Assertion macros for the sorted set store.
`ifndef SORTED_SET_STORE_ASSERT_SVH
`define SORTED_SET_STORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_set_store: check failed");

// Next-cycle implication.
`define SSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_set_store: check failed");

`endif

// ===== design/sss_pkg.sv =====
package sss_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_READ   = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INS,
    ST_REM,
    ST_RANK
  } state_t;

endpackage

// ===== design/sorted_set_store.sv =====
// Sorted set store: a set of signed values held in ascending order, no duplicates.
// Command channel: drive req_type, value and rank_index with start high; the word
// is taken at a rising edge where start is high and busy is low. Kinds are insert,
// remove, membership query and read at rank.
// Result channel: done is high for exactly one cycle with was_present,
// member_count, read_value and status; the receiver must take it then.
// Each command walks the store in one ascending pass through a single memory
// with a registered read port: reads run one entry ahead of the compare, and
// insert and remove write behind the read pointer, so no forwarding is needed.
// A command scans from position 0 in ST_SCAN up to its matching position; an
// insert that shifts entries then carries them up through ST_INS to the end of
// the set, a remove that shifts moves them down through ST_REM, and a rank read
// adds ST_RANK after the search. busy drops in the cycle done is high, so the
// next command can be taken in that same cycle.
// Reset clears the element count to zero; the memory contents are left as they
// are, and entries at or above the count are never used.
module sorted_set_store #(
  parameter int CAPACITY    = sss_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = sss_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] value,
  input  logic [5:0]         rank_index,
  output logic               done,
  output logic               was_present,
  output logic [6:0]         member_count,
  output logic signed [31:0] read_value,
  output logic [1:0]         status
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int EXT_W = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  localparam int RW    = (CW > 6) ? CW : 6;

  sss_pkg::state_t    state, state_next;
  sss_pkg::req_kind_t kind;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      pos, pos_next;
  logic [5:0]         rank;
  logic signed [VALUE_WIDTH-1:0] key;
  logic signed [VALUE_WIDTH-1:0] carry, carry_next;
  logic               present_q, present_next;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic signed [VALUE_WIDTH-1:0] wdata, rdata;

  logic signed [EXT_W-1:0] value_ext, rd_ext;
  logic [CW-1:0]      pos_inc, pos_dec;
  logic               scan_end, hit_ge, hit_eq, scan_stop, full, rank_ok, last;
  logic               finish, res_present;
  logic signed [31:0] res_value;
  sss_pkg::status_t   res_status;

  sss_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign value_ext = EXT_W'(value);
  assign rd_ext    = EXT_W'(rdata);
  assign pos_inc   = pos + CW'(1);
  assign pos_dec   = pos - CW'(1);
  assign scan_end  = (pos == count);
  assign hit_ge    = !scan_end && (rdata >= key);
  assign hit_eq    = !scan_end && (rdata == key);
  assign scan_stop = scan_end || hit_ge;
  assign full      = (count == CW'(CAPACITY));
  assign rank_ok   = (RW'(rank) < RW'(count));
  assign last      = (pos_inc == count);
  assign busy      = (state != sss_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      sss_pkg::ST_IDLE: begin
        if (start) begin
          state_next = sss_pkg::ST_SCAN;
        end
      end
      sss_pkg::ST_SCAN: begin
        if (scan_stop) begin
          case (kind)
            sss_pkg::REQ_INSERT: begin
              state_next = (!hit_eq && !full && !scan_end) ? sss_pkg::ST_INS
                                                           : sss_pkg::ST_IDLE;
            end
            sss_pkg::REQ_REMOVE: begin
              state_next = (hit_eq && !last) ? sss_pkg::ST_REM : sss_pkg::ST_IDLE;
            end
            sss_pkg::REQ_READ: begin
              state_next = rank_ok ? sss_pkg::ST_RANK : sss_pkg::ST_IDLE;
            end
            default: begin
              state_next = sss_pkg::ST_IDLE;
            end
          endcase
        end
      end
      sss_pkg::ST_INS: begin
        if (scan_end) begin
          state_next = sss_pkg::ST_IDLE;
        end
      end
      sss_pkg::ST_REM: begin
        if (last) begin
          state_next = sss_pkg::ST_IDLE;
        end
      end
      sss_pkg::ST_RANK: begin
        state_next = sss_pkg::ST_IDLE;
      end
      default: begin
        state_next = sss_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    we           = 1'b0;
    waddr        = pos[AW-1:0];
    wdata        = carry;
    // read one entry ahead of the compare
    raddr        = (pos_inc < CW'(CAPACITY)) ? pos_inc[AW-1:0] : '0;
    finish       = 1'b0;
    count_next   = count;
    pos_next     = pos;
    carry_next   = carry;
    present_next = present_q;
    res_present  = hit_eq;
    res_value    = '0;
    res_status   = sss_pkg::STATUS_OK;
    case (state)
      sss_pkg::ST_IDLE: begin
        raddr    = '0;
        pos_next = '0;
      end
      sss_pkg::ST_SCAN: begin
        if (!scan_stop) begin
          pos_next = pos_inc;
        end else begin
          case (kind)
            sss_pkg::REQ_INSERT: begin
              if (hit_eq) begin
                finish = 1'b1;
              end else if (full) begin
                finish     = 1'b1;
                res_status = sss_pkg::STATUS_FULL;
              end else begin
                we    = 1'b1;
                wdata = key;
                if (scan_end) begin
                  count_next = count + CW'(1);
                  finish     = 1'b1;
                end else begin
                  carry_next = rdata;
                  pos_next   = pos_inc;
                end
              end
            end
            sss_pkg::REQ_REMOVE: begin
              if (hit_eq && last) begin
                count_next = count - CW'(1);
                finish     = 1'b1;
              end else if (hit_eq) begin
                pos_next = pos_inc;
              end else begin
                finish = 1'b1;
              end
            end
            sss_pkg::REQ_READ: begin
              present_next = hit_eq;
              if (rank_ok) begin
                raddr = AW'(RW'(rank));
              end else begin
                finish     = 1'b1;
                res_status = sss_pkg::STATUS_RANGE;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      sss_pkg::ST_INS: begin
        // drop the carried entry here and pick up the one it displaces
        we          = 1'b1;
        res_present = 1'b0;
        if (scan_end) begin
          count_next = count + CW'(1);
          finish     = 1'b1;
        end else begin
          carry_next = rdata;
          pos_next   = pos_inc;
        end
      end
      sss_pkg::ST_REM: begin
        // move each entry down by one over the removed slot
        we          = 1'b1;
        waddr       = pos_dec[AW-1:0];
        wdata       = rdata;
        res_present = 1'b1;
        if (last) begin
          count_next = count - CW'(1);
          finish     = 1'b1;
        end else begin
          pos_next = pos_inc;
        end
      end
      sss_pkg::ST_RANK: begin
        finish      = 1'b1;
        res_present = present_q;
        res_value   = rd_ext[31:0];
      end
      default: begin
        finish = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sss_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    pos       <= pos_next;
    carry     <= carry_next;
    present_q <= present_next;
    if (start && !busy) begin
      kind <= sss_pkg::req_kind_t'(req_type);
      key  <= value_ext[VALUE_WIDTH-1:0];
      rank <= rank_index;
    end
    if (finish) begin
      was_present  <= res_present;
      member_count <= 7'(count_next);
      read_value   <= res_value;
      status       <= res_status;
    end
  end

`include "sorted_set_store_assert.svh"

  `SSS_ASSERT_IMP(a_count_cap, 1'b1, count <= CW'(CAPACITY))
  `SSS_ASSERT_IMP(a_done_idle, done, state == sss_pkg::ST_IDLE)
  `SSS_ASSERT_IMP(a_write_bound, we, CW'(waddr) <= count)
  `SSS_ASSERT_IMP(a_full_count, done && status == sss_pkg::STATUS_FULL, full)

endmodule

// ===== design/sss_mem.sv =====
module sss_mem #(
  parameter int DEPTH = sss_pkg::CAPACITY_DEF,
  parameter int WIDTH = sss_pkg::VALUE_WIDTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic signed [WIDTH-1:0] wdata,
  input  logic [AW-1:0]           raddr,
  output logic signed [WIDTH-1:0] rdata
);

  logic signed [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
